>>> sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and the microprogram of the software timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int CMD_W    = 2;
    localparam int DELAY_W  = 16;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 2;
    localparam int UPC_W    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NULL_ID = 2'd3
    } status_t;

    // one table entry as stored in the slot RAM
    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] count;
        logic               periodic;
        logic [ID_W-1:0]    owner;
    } entry_t;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t U_IDLE    = 4'd0;
    localparam upc_t U_TICK    = 4'd1;
    localparam upc_t U_SCAN    = 4'd2;
    localparam upc_t U_TEST    = 4'd3;
    localparam upc_t U_TAIL    = 4'd4;
    localparam upc_t U_MOVE    = 4'd5;
    localparam upc_t U_FIN     = 4'd6;
    localparam upc_t U_START   = 4'd7;
    localparam upc_t U_CHKFULL = 4'd8;
    localparam upc_t U_APPEND  = 4'd9;
    localparam upc_t U_STOP    = 4'd10;

    typedef enum logic [2:0] {
        C_ALWAYS    = 3'd0,
        C_DISPATCH  = 3'd1,
        C_CNT_ZERO  = 3'd2,
        C_ID_NULL   = 3'd3,
        C_FULL      = 3'd4,
        C_SCAN_DONE = 3'd5,
        C_REMOVE    = 3'd6
    } cond_sel_t;

    typedef enum logic [1:0] {
        H_NONE = 2'd0,
        H_IN   = 2'd1,
        H_PUSH = 2'd2,
        H_OUT  = 2'd3
    } hold_sel_t;

    // control word: actions, hold source, branch condition and two targets
    typedef struct packed {
        logic      accept;
        logic      clr_idx;
        logic      rd_idx;
        logic      rd_tail;
        logic      test;
        logic      wr_move;
        logic      wr_new;
        logic      emit_final;
        cond_sel_t cond;
        hold_sel_t hold;
        logic      set_status;
        status_t   status;
        upc_t      tgt_t;
        upc_t      tgt_f;
    } ctl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        cmd_t command;
        logic cnt_zero;
        logic id_null;
        logic full;
        logic scan_done;
        logic remove;
        logic push_busy;
        logic out_busy;
    } flags_t;

    function automatic ctl_t ucode(input upc_t pc);
        ctl_t w;
        w = '0;
        unique case (pc)
            U_IDLE:
            begin
                w.accept = 1'b1;
                w.hold   = H_IN;
                w.cond   = C_DISPATCH;
            end
            U_TICK:
            begin
                w.clr_idx    = 1'b1;
                w.cond       = C_CNT_ZERO;
                w.set_status = 1'b1;
                w.status     = ST_EMPTY;
                w.tgt_t      = U_FIN;
                w.tgt_f      = U_SCAN;
            end
            U_SCAN:
            begin
                w.rd_idx = 1'b1;
                w.cond   = C_SCAN_DONE;
                w.tgt_t  = U_FIN;
                w.tgt_f  = U_TEST;
            end
            U_TEST:
            begin
                w.test  = 1'b1;
                w.hold  = H_PUSH;
                w.cond  = C_REMOVE;
                w.tgt_t = U_TAIL;
                w.tgt_f = U_SCAN;
            end
            U_TAIL:
            begin
                w.rd_tail = 1'b1;
                w.tgt_t   = U_MOVE;
            end
            U_MOVE:
            begin
                w.wr_move = 1'b1;
                w.tgt_t   = U_SCAN;
            end
            U_FIN:
            begin
                w.emit_final = 1'b1;
                w.hold       = H_OUT;
                w.tgt_t      = U_IDLE;
            end
            U_START:
            begin
                w.cond       = C_ID_NULL;
                w.set_status = 1'b1;
                w.status     = ST_NULL_ID;
                w.tgt_t      = U_FIN;
                w.tgt_f      = U_CHKFULL;
            end
            U_CHKFULL:
            begin
                w.cond       = C_FULL;
                w.set_status = 1'b1;
                w.status     = ST_FULL;
                w.tgt_t      = U_FIN;
                w.tgt_f      = U_APPEND;
            end
            U_APPEND:
            begin
                w.wr_new = 1'b1;
                w.tgt_t  = U_FIN;
            end
            U_STOP:
            begin
                w.clr_idx    = 1'b1;
                w.cond       = C_ID_NULL;
                w.set_status = 1'b1;
                w.status     = ST_NULL_ID;
                w.tgt_t      = U_FIN;
                w.tgt_f      = U_SCAN;
            end
            default:
            begin
                w.tgt_t = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/stt_cmd_if.sv
// ----------------------------------------------------------------------------
// stt_cmd_if
// Command channel: valid/ready handshake with one command item.
// ----------------------------------------------------------------------------
interface stt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] delay_ticks;
    logic        periodic;
    logic [7:0]  callback_id;

    modport source (output valid, command, delay_ticks, periodic, callback_id, input ready);
    modport sink   (input valid, command, delay_ticks, periodic, callback_id, output ready);
endinterface

>>> sv/stt_rsp_if.sv
// ----------------------------------------------------------------------------
// stt_rsp_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface stt_rsp_if;
    logic       valid;
    logic       ready;
    logic       fired;
    logic [7:0] fired_id;
    logic [1:0] status;
    logic       last;

    modport source (output valid, fired, fired_id, status, last, input ready);
    modport sink   (input valid, fired, fired_id, status, last, output ready);
endinterface

>>> sv/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
    parameter int WIDTH  = 41,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/stt_useq.sv
// ----------------------------------------------------------------------------
// stt_useq
// Microsequencer: step counter, control-word ROM, hold and branch logic.
// ----------------------------------------------------------------------------
module stt_useq (
    input  logic          clk,
    input  logic          rst_n,
    input  stt_pkg::flags_t flags,
    output stt_pkg::ctl_t ctl,
    output logic          go,
    output logic          taken
);
    import stt_pkg::*;

    upc_t pc_reg;
    upc_t pc_next;
    upc_t dispatch_pc;
    logic held;

    assign ctl = ucode(pc_reg);

    always_comb
    begin
        unique case (ctl.hold)
            H_NONE: held = 1'b0;
            H_IN:   held = !flags.in_valid;
            H_PUSH: held = flags.push_busy;
            H_OUT:  held = flags.out_busy;
            default: held = 1'b0;
        endcase
    end

    assign go = !held;

    always_comb
    begin
        unique case (flags.command)
            CMD_TICK:  dispatch_pc = U_TICK;
            CMD_START: dispatch_pc = U_START;
            CMD_STOP:  dispatch_pc = U_STOP;
            default:   dispatch_pc = U_FIN;
        endcase
    end

    always_comb
    begin
        unique case (ctl.cond)
            C_ALWAYS:    taken = 1'b1;
            C_DISPATCH:  taken = 1'b1;
            C_CNT_ZERO:  taken = flags.cnt_zero;
            C_ID_NULL:   taken = flags.id_null;
            C_FULL:      taken = flags.full;
            C_SCAN_DONE: taken = flags.scan_done;
            C_REMOVE:    taken = flags.remove;
            default:     taken = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (go)
        begin
            if (ctl.cond == C_DISPATCH)
            begin
                pc_next = dispatch_pc;
            end
            else
            begin
                pc_next = taken ? ctl.tgt_t : ctl.tgt_f;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= U_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // the step counter never leaves the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= U_STOP)
        else $error("step counter outside program");

    a_hold_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(pc_reg))
        else $error("step counter moved while held");

    a_dispatch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cond == C_DISPATCH) |-> (pc_reg == U_IDLE))
        else $error("dispatch outside the idle step");
endmodule

>>> sv/stt_datapath.sv
// ----------------------------------------------------------------------------
// stt_datapath
// Slot RAM, entry count, scan index, pending fire and result register.
// ----------------------------------------------------------------------------
module stt_datapath #(
    parameter int TIMER_SLOTS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    stt_cmd_if.sink         cmd,
    stt_rsp_if.source       rsp,
    input  stt_pkg::ctl_t   ctl,
    input  logic            go,
    input  logic            taken,
    output stt_pkg::flags_t flags
);
    import stt_pkg::*;

    localparam int IDX_W   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W   = $clog2(TIMER_SLOTS + 1);
    localparam int ENTRY_W = $bits(entry_t);

    // latched command
    cmd_t               cmd_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               per_reg;
    logic [ID_W-1:0]    id_reg;
    status_t            status_reg;

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   tail_full;

    logic               pend_valid_reg;
    logic [ID_W-1:0]    pend_id_reg;

    logic               out_valid_reg;
    logic               out_fired_reg;
    logic [ID_W-1:0]    out_id_reg;
    status_t            out_status_reg;
    logic               out_last_reg;

    logic               accepted;
    entry_t             rd_entry;
    entry_t             wb_entry;
    entry_t             new_entry;
    logic [ENTRY_W-1:0] rdata;
    logic [DELAY_W-1:0] inc_count;
    logic               tick_hit;
    logic               stop_hit;
    logic               remove;
    logic               push_prev;
    logic               load_fin;
    logic               out_busy;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;

    assign accepted  = cmd.valid && cmd.ready;
    assign cmd.ready = ctl.accept;

    assign rd_entry  = entry_t'(rdata);
    assign inc_count = rd_entry.count + DELAY_W'(1);
    assign tick_hit  = (cmd_reg == CMD_TICK) && (rd_entry.delay != '0)
                       && (inc_count == rd_entry.delay);
    assign stop_hit  = (cmd_reg == CMD_STOP) && (rd_entry.owner == id_reg);
    assign remove    = stop_hit || (tick_hit && !rd_entry.periodic);
    assign tail_full = cnt_reg - CNT_W'(1);
    assign out_busy  = out_valid_reg && !rsp.ready;

    assign push_prev = go && ctl.test && tick_hit && pend_valid_reg;
    assign load_fin  = go && ctl.emit_final;

    always_comb
    begin
        flags.in_valid  = cmd.valid;
        flags.command   = cmd_t'(cmd.command);
        flags.cnt_zero  = (cnt_reg == '0);
        flags.id_null   = (id_reg == '0);
        flags.full      = (cnt_reg == CNT_W'(TIMER_SLOTS));
        flags.scan_done = (idx_reg >= cnt_reg);
        flags.remove    = remove;
        flags.push_busy = tick_hit && pend_valid_reg && out_busy;
        flags.out_busy  = out_busy;
    end

    // write-back of a surviving entry during a tick scan
    always_comb
    begin
        wb_entry       = rd_entry;
        wb_entry.count = tick_hit ? '0 : inc_count;
    end

    always_comb
    begin
        new_entry.delay    = delay_reg;
        new_entry.count    = '0;
        new_entry.periodic = per_reg;
        new_entry.owner    = id_reg;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = wb_entry;
        priority if (go && ctl.wr_new)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[IDX_W-1:0];
            ram_wdata = new_entry;
        end
        else if (go && ctl.wr_move)
        begin
            ram_we    = 1'b1;
            ram_wdata = rdata;
        end
        else if (go && ctl.test && (cmd_reg == CMD_TICK) && !remove)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_re    = go && ((ctl.rd_idx && !flags.scan_done) || ctl.rd_tail);
    assign ram_raddr = ctl.rd_tail ? tail_full[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    stt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TIMER_SLOTS),
        .ADDR_W(IDX_W)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        if (go && ctl.wr_new)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (go && ctl.rd_tail)
        begin
            cnt_next = tail_full;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (go && ctl.clr_idx)
        begin
            idx_next = '0;
        end
        else if (go && ctl.test && !remove)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            idx_reg        <= '0;
            status_reg     <= ST_OK;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;

            if (accepted)
            begin
                status_reg     <= ST_OK;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (go && ctl.set_status && taken)
                begin
                    status_reg <= ctl.status;
                end
                if (go && ctl.test && tick_hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end

            if (push_prev || load_fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            cmd_reg   <= cmd_t'(cmd.command);
            delay_reg <= cmd.delay_ticks;
            per_reg   <= cmd.periodic;
            id_reg    <= cmd.callback_id;
        end
        if (go && ctl.test && tick_hit)
        begin
            pend_id_reg <= rd_entry.owner;
        end
        // a new fire pushes the previous one out; it cannot be the last
        if (push_prev)
        begin
            out_fired_reg  <= 1'b1;
            out_id_reg     <= pend_id_reg;
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b0;
        end
        else if (load_fin)
        begin
            out_fired_reg  <= pend_valid_reg;
            out_id_reg     <= pend_valid_reg ? pend_id_reg : '0;
            out_status_reg <= status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.fired    = out_fired_reg;
    assign rsp.fired_id = out_id_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.last     = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TIMER_SLOTS))
        else $error("entry count above table size");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (go && ctl.wr_new) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("append did not grow the table");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        load_fin |=> (out_valid_reg && out_last_reg))
        else $error("closing result not marked last");

    a_push_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        push_prev |=> (out_valid_reg && out_fired_reg && !out_last_reg))
        else $error("intermediate fire transfer malformed");
endmodule

>>> sv/software_timer_table.sv
// ----------------------------------------------------------------------------
// software_timer_table
// Table of software timers run by a microcoded sequencer over a slot RAM.
// ----------------------------------------------------------------------------
//  channel  dir   payload                                         per transfer
//  cmd      in    command, delay_ticks, periodic, callback_id     one command
//  rsp      out   fired, fired_id, status, last                   one result
//
//  Start, tick on empty, unused code: the result loads in the closing step,
//  and the next command is taken in the idle step that follows it.
//  Tick: for each entry a read, then a test on the registered read data;
//  a one-shot removal adds a read of the tail entry and a move into its slot.
//  Stop: the same scan, with a tail read and a move per removed entry.
//  A fire waits as pending; a later fire pushes it to the output register,
//  and the scan stalls only when such a fire finds it still untaken. The
//  closing step waits for the output to drain. No clearing pass after reset.
// ----------------------------------------------------------------------------
module software_timer_table #(
    parameter int TIMER_SLOTS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    stt_cmd_if.sink   cmd,
    stt_rsp_if.source rsp
);
    import stt_pkg::*;

    ctl_t   ctl;
    flags_t flags;
    logic   go;
    logic   taken;

    stt_useq u_useq (
        .clk  (clk),
        .rst_n(rst_n),
        .flags(flags),
        .ctl  (ctl),
        .go   (go),
        .taken(taken)
    );

    stt_datapath #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) u_datapath (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .rsp  (rsp),
        .ctl  (ctl),
        .go   (go),
        .taken(taken),
        .flags(flags)
    );
endmodule
